FILE: hdl/orientation_debounce_rotation_select_assert.svh
// assertion macros used by the checker file
`ifndef ORIENTATION_DEBOUNCE_ROTATION_SELECT_ASSERT_SVH
`define ORIENTATION_DEBOUNCE_ROTATION_SELECT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ORDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ords assertion failed");

// next-cycle implication, disabled while reset is low
`define ORDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ords assertion failed");

`endif

FILE: hdl/ords_pkg.sv
`timescale 1ns / 1ps
package ords_pkg;

	// item commands
	typedef enum logic [1:0] {
		CMD_READING = 2'd0,
		CMD_BINDING = 2'd1,
		CMD_TICK    = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_ROTATION_LOCK  = 2'd0,
		REG_ROTATE_DELAY   = 2'd1,
		REG_UPRIGHT_DELAY  = 2'd2,
		REG_SENSOR_ENABLE  = 2'd3
	} reg_idx_t;

	localparam int          CFG_DATA_W       = 16;
	localparam int          DELAY_W          = 16;
	localparam logic [15:0] ROT_DELAY_RESET  = 16'd500;
	localparam logic [15:0] UP_DELAY_RESET   = 16'd1200;

	// orientation codes, NONE_SET also marks an empty override or sensor slot
	localparam logic [2:0]  ORIENT_NORMAL    = 3'd0;
	localparam logic [2:0]  NONE_SET         = 3'd4;

	typedef struct packed {
		logic               rotation_lock;
		logic [DELAY_W-1:0] rotate_delay;
		logic [DELAY_W-1:0] upright_delay;
		logic               sensor_enable;
	} cfg_t;

	typedef struct packed {
		logic [1:0] transform;
		logic       transform_changed;
		logic       binding_result;
	} result_t;

endpackage

FILE: hdl/ords_in_if.sv
`timescale 1ns / 1ps
interface ords_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [2:0] orientation;
	logic       binding_allowed;

	modport source (output valid, cmd, orientation, binding_allowed, input ready);
	modport sink (input valid, cmd, orientation, binding_allowed, output ready);
endinterface

FILE: hdl/ords_out_if.sv
`timescale 1ns / 1ps
interface ords_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] transform;
	logic       transform_changed;
	logic       binding_result;

	modport source (output valid, transform, transform_changed, binding_result, input ready);
	modport sink (input valid, transform, transform_changed, binding_result, output ready);
endinterface

FILE: hdl/ords_cfg.sv
`timescale 1ns / 1ps
module ords_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [ords_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output ords_pkg::cfg_t            cfg
);
	import ords_pkg::*;

	cfg_t cfg_q;
	reg_idx_t idx;

	assign idx = reg_idx_t'(cfg_index);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotation_lock <= 1'b0;
			cfg_q.rotate_delay  <= ROT_DELAY_RESET;
			cfg_q.upright_delay <= UP_DELAY_RESET;
			cfg_q.sensor_enable <= 1'b1;
		end else if (cfg_we) begin
			unique case (idx)
				REG_ROTATION_LOCK: cfg_q.rotation_lock <= cfg_wdata[0];
				REG_ROTATE_DELAY:  cfg_q.rotate_delay  <= cfg_wdata[DELAY_W-1:0];
				REG_UPRIGHT_DELAY: cfg_q.upright_delay <= cfg_wdata[DELAY_W-1:0];
				REG_SENSOR_ENABLE: cfg_q.sensor_enable <= cfg_wdata[0];
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

FILE: hdl/ords_core.sv
`timescale 1ns / 1ps
module ords_core #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ords_pkg::cfg_t    cfg,
	input  logic              step_en,
	input  logic [1:0]        cmd,
	input  logic [2:0]        orientation,
	input  logic              binding_allowed,
	output ords_pkg::result_t result
);
	import ords_pkg::*;

	logic [2:0]             override_q, override_n;
	logic [2:0]             confirmed_q, confirmed_n;
	logic [1:0]             pending_q, pending_n;
	logic                   active_q, active_n;
	logic [TIMER_WIDTH-1:0] remain_q, remain_n, remain_dec;
	logic [1:0]             applied_q, applied_n;
	logic                   eval, changed;
	logic                   want_valid;
	logic [1:0]             want;
	logic                   new_up, pend_up, orient_ok;
	cmd_t                   cmd_e;

	// delay load value: zero acts as one, saturate to the timer range
	function automatic logic [TIMER_WIDTH-1:0] arm_value(input logic [DELAY_W-1:0] delay);
		logic [DELAY_W-1:0] d;
		d = (delay == '0) ? DELAY_W'(1) : delay;
		if ((d >> TIMER_WIDTH) != '0)
			arm_value = '1;
		else
			arm_value = TIMER_WIDTH'(d);
	endfunction

	assign cmd_e      = cmd_t'(cmd);
	assign orient_ok  = !orientation[2];
	assign new_up     = (orientation == ORIENT_NORMAL);
	assign pend_up    = (pending_q == ORIENT_NORMAL[1:0]);
	assign remain_dec = remain_q - TIMER_WIDTH'(1);

	// next state for reading, binding and tick
	always_comb begin
		override_n  = override_q;
		confirmed_n = confirmed_q;
		pending_n   = pending_q;
		active_n    = active_q;
		remain_n    = remain_q;
		eval        = 1'b0;
		unique case (cmd_e)
			CMD_READING: begin
				if (cfg.sensor_enable && orient_ok) begin
					if (!active_q) begin
						if (orientation != confirmed_q) begin
							pending_n = orientation[1:0];
							active_n  = 1'b1;
							remain_n  = arm_value(new_up ? cfg.upright_delay : cfg.rotate_delay);
						end
					end else if (!pend_up) begin
						if (!new_up)
							pending_n = orientation[1:0];
					end else if (!new_up) begin
						pending_n = orientation[1:0];
						remain_n  = arm_value(cfg.rotate_delay);
					end
				end
			end
			CMD_BINDING: begin
				if (binding_allowed && orient_ok) begin
					override_n = (orientation == override_q) ? NONE_SET : orientation;
					eval       = 1'b1;
				end
			end
			CMD_TICK: begin
				if (active_q) begin
					remain_n = remain_dec;
					if (remain_dec == '0) begin
						active_n    = 1'b0;
						confirmed_n = {1'b0, pending_q};
						eval        = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// transform choice: override first, then the unlocked sensor
	always_comb begin
		want_valid = 1'b0;
		want       = override_n[1:0];
		if (!override_n[2]) begin
			want_valid = 1'b1;
		end else if (!confirmed_n[2] && !cfg.rotation_lock) begin
			want_valid = 1'b1;
			want       = confirmed_n[1:0];
		end
		changed   = eval && want_valid && (want != applied_q);
		applied_n = changed ? want : applied_q;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			override_q  <= NONE_SET;
			confirmed_q <= NONE_SET;
			pending_q   <= '0;
			active_q    <= 1'b0;
			remain_q    <= '0;
			applied_q   <= '0;
		end else if (step_en) begin
			override_q  <= override_n;
			confirmed_q <= confirmed_n;
			pending_q   <= pending_n;
			active_q    <= active_n;
			remain_q    <= remain_n;
			applied_q   <= applied_n;
		end
	end

	assign result.transform         = applied_n;
	assign result.transform_changed = changed;
	assign result.binding_result    = changed && (cmd_e == CMD_BINDING);
endmodule

FILE: hdl/orientation_debounce_rotation_select.sv
`timescale 1ns / 1ps
// Display rotation selector.
// in_ch carries sensor readings, user rotation bindings and 1 ms ticks
// (cmd field); out_ch returns one result per input item, in order: the
// applied transform, whether this item changed it, and for a binding
// whether the binding caused the change.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata) for
// rotation lock, the two debounce delays and sensor enable; write it only
// while no item is in flight.
// From input transfer to the earliest result transfer an item passes
// one input register, then the state update and result register, which
// drives out_ch.valid. Throughput is one item per cycle while the
// receiver does not stall; the state update of each item is combinational
// compare and decrement logic on the TIMER_WIDTH debounce counter.
// When the receiver stalls, the result register holds and the input stage
// fills; in_ch.ready drops once both stages are occupied.
// Reset clears both stages, sets no override and no confirmed sensor
// reading, stops the timer, applies the normal transform and loads the
// register reset values.
module orientation_debounce_rotation_select #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ords_in_if.sink                         in_ch,
	ords_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [ords_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import ords_pkg::*;

	cfg_t       cfg;
	result_t    result;
	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [2:0] orient_s1;
	logic       allowed_s1;
	logic       valid_s2;
	result_t    result_s2;
	logic       adv_s2, adv_s1;

	ords_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// stage advance
	assign adv_s2      = !valid_s2 || out_ch.ready;
	assign adv_s1      = valid_s1 && adv_s2;
	assign in_ch.ready = !valid_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.ready)
			valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cmd_s1     <= in_ch.cmd;
			orient_s1  <= in_ch.orientation;
			allowed_s1 <= in_ch.binding_allowed;
		end
	end

	ords_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.step_en         (adv_s1),
		.cmd             (cmd_s1),
		.orientation     (orient_s1),
		.binding_allowed (allowed_s1),
		.result          (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv_s2)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			result_s2 <= result;
	end

	assign out_ch.valid             = valid_s2;
	assign out_ch.transform         = result_s2.transform;
	assign out_ch.transform_changed = result_s2.transform_changed;
	assign out_ch.binding_result    = result_s2.binding_result;
endmodule

FILE: hdl/ords_checker.sv
`timescale 1ns / 1ps
`include "orientation_debounce_rotation_select_assert.svh"
module ords_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] transform,
	input logic       transform_changed,
	input logic       binding_result
);
	logic [1:0] last_q;
	logic       xfer;

	assign xfer = out_valid && out_ready;

	// transform of the last result transfer, normal after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_q <= 2'd0;
		else if (xfer)
			last_q <= transform;
	end

	`ORDS_ASSERT_IMPL(a_bres_implies_change, clk, arst_n,
		out_valid && binding_result, transform_changed)
	`ORDS_ASSERT_IMPL(a_hold_when_unchanged, clk, arst_n,
		out_valid && !transform_changed, transform == last_q)
	`ORDS_ASSERT_IMPL(a_new_when_changed, clk, arst_n,
		out_valid && transform_changed, transform != last_q)
	`ORDS_ASSERT_NEXT(a_stall_holds, clk, arst_n,
		out_valid && !out_ready, out_valid && $stable(transform))
endmodule

bind orientation_debounce_rotation_select ords_checker u_ords_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_ch.valid),
	.out_ready         (out_ch.ready),
	.transform         (out_ch.transform),
	.transform_changed (out_ch.transform_changed),
	.binding_result    (out_ch.binding_result)
);
